// File: src/madc_pkg.sv
// ----------------------------------------------------------------------------
// madc_pkg - motor ADC conditioner shared definitions
// Widths, register indexes and reset values used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package madc_pkg;

    localparam int ADC_BITS_DEF = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CUR_W  = 21;
    localparam int TEMP_W = 15;
    localparam int VOUT_W = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VBUS_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VBUS_SCALE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_BC       = 3'd6;

    // reset values
    localparam logic [15:0] RST_OFFSET_GAIN   = 16'd16;
    localparam logic [15:0] RST_MIX_GAIN      = 16'd39322;
    localparam logic [15:0] RST_VBUS_GAIN     = 16'd3197;
    localparam logic [15:0] RST_CURRENT_SCALE = 16'd256;
    localparam logic [15:0] RST_VBUS_SCALE    = 16'd256;
    localparam logic [11:0] RST_TEMP_CAL      = 12'd2048;
    localparam logic [35:0] RST_VBUS_ACC      = 36'd12000 << 16;

    typedef logic signed [CUR_W-1:0] t_current;

endpackage

`default_nettype wire

// File: src/madc_if.sv
// ----------------------------------------------------------------------------
// madc interfaces - valid/ready channels of the conditioner
// Sample input, measurement output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface madc_in_if #(
    parameter int ADC_BITS = madc_pkg::ADC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] offset_sample_a;
    logic [ADC_BITS-1:0] offset_sample_b;
    logic [ADC_BITS-1:0] offset_sample_c;
    logic [ADC_BITS-1:0] current_sample_a;
    logic [ADC_BITS-1:0] current_sample_b;
    logic [ADC_BITS-1:0] current_sample_c;
    logic [ADC_BITS-1:0] temp_sample;
    logic [ADC_BITS-1:0] vbus_sample;

    modport source (
        output valid, offset_sample_a, offset_sample_b, offset_sample_c,
        output current_sample_a, current_sample_b, current_sample_c,
        output temp_sample, vbus_sample,
        input  ready
    );
    modport sink (
        input  valid, offset_sample_a, offset_sample_b, offset_sample_c,
        input  current_sample_a, current_sample_b, current_sample_c,
        input  temp_sample, vbus_sample,
        output ready
    );
endinterface

interface madc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [madc_pkg::CUR_W-1:0]  current_a;
    logic signed [madc_pkg::CUR_W-1:0]  current_b;
    logic signed [madc_pkg::CUR_W-1:0]  current_c;
    logic signed [madc_pkg::TEMP_W-1:0] die_temp;
    logic [madc_pkg::VOUT_W-1:0]        bus_voltage;

    modport source (
        output valid, current_a, current_b, current_c, die_temp, bus_voltage,
        input  ready
    );
    modport sink (
        input  valid, current_a, current_b, current_c, die_temp, bus_voltage,
        output ready
    );
endinterface

interface madc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [madc_pkg::CFG_IDX_W-1:0]  index;
    logic [madc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/motor_adc_measurement_conditioner.sv
// ----------------------------------------------------------------------------
// motor_adc_measurement_conditioner - shunt current and sensor conditioning
// Offset tracking, common-mode rejection, die temperature and bus filter.
// ----------------------------------------------------------------------------
// Sample sets are taken only in idle, so a new set waits until the last one's
// result is registered; nine products run one after the other on a single
// shift-add multiplier taking one multiplier bit per cycle.
// Temperature divide runs alongside on a bit-serial restoring divider.
// Reset (synchronous): registers to defaults, offsets cleared, bus filter 12 V.
`default_nettype none

module motor_adc_measurement_conditioner #(
    parameter int ADC_BITS = madc_pkg::ADC_BITS_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    madc_in_if.sink    i_in,
    madc_out_if.source o_out,
    madc_cfg_if.sink   i_cfg
);
    import madc_pkg::*;

    localparam int W  = ADC_BITS;
    localparam int MW = (W + 21 > 37) ? W + 21 : 37;
    localparam int PW = MW + 16;
    localparam int NW = W + 16;
    localparam int DCW = $clog2(NW + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_STORE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [3:0] OP_OFF_A = 4'd0;
    localparam logic [3:0] OP_OFF_B = 4'd1;
    localparam logic [3:0] OP_OFF_C = 4'd2;
    localparam logic [3:0] OP_MIX   = 4'd3;
    localparam logic [3:0] OP_CUR_A = 4'd4;
    localparam logic [3:0] OP_CUR_B = 4'd5;
    localparam logic [3:0] OP_CUR_C = 4'd6;
    localparam logic [3:0] OP_VTGT  = 4'd7;
    localparam logic [3:0] OP_VFILT = 4'd8;

    localparam logic signed [PW-1:0] CUR_HI = PW'(1048575);
    localparam logic signed [PW-1:0] CUR_LO = -PW'(1048576);
    localparam logic signed [PW-1:0] RND24  = PW'(8388608);

    // configuration
    logic [15:0] r_offset_gain, r_mix_gain, r_vbus_gain;
    logic [15:0] r_current_scale, r_vbus_scale;
    logic [11:0] r_temp_cal;
    logic        r_swap_bc;

    // state
    logic [W+15:0] r_off_a, r_off_b, r_off_c;
    logic [35:0]   r_vacc;

    // captured samples
    logic [W-1:0] r_s_off_a, r_s_off_b, r_s_off_c;
    logic [W-1:0] r_s_cur_a, r_s_cur_b, r_s_cur_c;
    logic [W-1:0] r_s_vbus;

    // sequencer and multiplier
    logic [2:0]           r_state;
    logic [3:0]           r_op;
    logic [3:0]           r_cnt;
    logic signed [PW-1:0] r_mcand;
    logic [15:0]          r_mplier;
    logic signed [PW-1:0] r_prod;

    // intermediates
    logic signed [W+19:0] r_kfl;
    t_current             r_cur_a, r_cur_b, r_cur_c;
    logic [35:0]          r_target;

    // divider
    logic            r_div_busy;
    logic [DCW-1:0]  r_dcnt;
    logic [NW-1:0]   r_dnum;
    logic [19:0]     r_drem;
    logic [18:0]     r_den;

    // output register
    logic                     r_out_valid;
    t_current                 r_o_cur_a, r_o_cur_b, r_o_cur_c;
    logic signed [TEMP_W-1:0] r_o_temp;
    logic [VOUT_W-1:0]        r_o_vbus;

    logic in_acc;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // ---------------- datapath operands ----------------
    logic signed [W+16:0] w_odiff_a, w_odiff_b, w_odiff_c;
    logic signed [W+16:0] w_ix_a, w_ix_b, w_ix_c;
    logic signed [W+18:0] w_sum;
    logic signed [W+20:0] w_m_a, w_m_b, w_m_c;
    logic signed [36:0]   w_vdiff;
    logic signed [MW-1:0] w_mcand;
    logic [15:0]          w_mplier;

    assign w_odiff_a = $signed({1'b0, r_s_off_a, 16'h0}) - $signed({1'b0, r_off_a});
    assign w_odiff_b = $signed({1'b0, r_s_off_b, 16'h0}) - $signed({1'b0, r_off_b});
    assign w_odiff_c = $signed({1'b0, r_s_off_c, 16'h0}) - $signed({1'b0, r_off_c});
    assign w_ix_a    = $signed({1'b0, r_s_cur_a, 16'h0}) - $signed({1'b0, r_off_a});
    assign w_ix_b    = $signed({1'b0, r_s_cur_b, 16'h0}) - $signed({1'b0, r_off_b});
    assign w_ix_c    = $signed({1'b0, r_s_cur_c, 16'h0}) - $signed({1'b0, r_off_c});
    assign w_sum     = (W+19)'(w_ix_a) + (W+19)'(w_ix_b) + (W+19)'(w_ix_c);
    // m = i_x - ceil(k*S / 2^16), r_kfl holds the negated ceiling
    assign w_m_a     = (W+21)'(w_ix_a) + (W+21)'(r_kfl);
    assign w_m_b     = (W+21)'(w_ix_b) + (W+21)'(r_kfl);
    assign w_m_c     = (W+21)'(w_ix_c) + (W+21)'(r_kfl);
    assign w_vdiff   = $signed({1'b0, r_target}) - $signed({1'b0, r_vacc});

    always_comb begin
        w_mcand  = '0;
        w_mplier = '0;
        unique case (r_op)
            OP_OFF_A: begin w_mcand = MW'(w_odiff_a); w_mplier = r_offset_gain; end
            OP_OFF_B: begin w_mcand = MW'(w_odiff_b); w_mplier = r_offset_gain; end
            OP_OFF_C: begin w_mcand = MW'(w_odiff_c); w_mplier = r_offset_gain; end
            OP_MIX:   begin w_mcand = MW'(w_sum);     w_mplier = r_mix_gain;    end
            OP_CUR_A: begin w_mcand = MW'(w_m_a);     w_mplier = r_current_scale; end
            OP_CUR_B: begin w_mcand = MW'(w_m_b);     w_mplier = r_current_scale; end
            OP_CUR_C: begin w_mcand = MW'(w_m_c);     w_mplier = r_current_scale; end
            OP_VTGT:  begin
                w_mcand  = MW'($signed({1'b0, r_s_vbus}));
                w_mplier = r_vbus_scale;
            end
            OP_VFILT: begin w_mcand = MW'(w_vdiff);   w_mplier = r_vbus_gain;   end
            default:  begin w_mcand = '0;             w_mplier = '0;            end
        endcase
    end

    // ---------------- product post-processing ----------------
    logic signed [PW-1:0] w_sh16, w_nk, w_rnd, w_csh;
    t_current             w_csat;
    logic [35:0]          w_tgt;

    assign w_sh16 = r_prod >>> 16;
    assign w_nk   = (-r_prod) >>> 16;
    assign w_rnd  = r_prod + RND24;
    assign w_csh  = w_rnd >>> 24;

    always_comb begin
        if (w_csh > CUR_HI) begin
            w_csat = CUR_HI[CUR_W-1:0];
        end else if (w_csh < CUR_LO) begin
            w_csat = CUR_LO[CUR_W-1:0];
        end else begin
            w_csat = w_csh[CUR_W-1:0];
        end
    end

    // target in Q.16 is product times 256, capped at 36 bits
    always_comb begin
        if (|r_prod[PW-1:28]) begin
            w_tgt = '1;
        end else begin
            w_tgt = {r_prod[27:0], 8'h0};
        end
    end

    // ---------------- temperature ----------------
    logic [NW-1:0] w_tnum;
    logic [18:0]   w_den;
    logic [19:0]   w_rsh, w_rsub;
    logic          w_ge;
    logic signed [TEMP_W-1:0] w_temp;

    assign w_tnum = NW'(300) * (NW'(i_in.temp_sample) * NW'(100) + NW'(12288));
    assign w_den  = 19'(r_temp_cal) * 19'd100 + 19'd12288;
    assign w_rsh  = {r_drem[18:0], r_dnum[NW-1]};
    assign w_ge   = (w_rsh >= {1'b0, r_den});
    assign w_rsub = w_rsh - {1'b0, r_den};

    always_comb begin
        if (r_dnum > NW'(16656)) begin
            w_temp = TEMP_W'(16383);
        end else begin
            w_temp = $signed(TEMP_W'(r_dnum) - TEMP_W'(273));
        end
    end

    logic [36:0] w_vround;
    logic [VOUT_W-1:0] w_vout;
    assign w_vround = {1'b0, r_vacc} + 37'd32768;
    assign w_vout   = w_vround[36] ? '1 : w_vround[35:16];

    logic out_free;
    assign out_free = !r_out_valid || o_out.ready;

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_gain   <= RST_OFFSET_GAIN;
            r_mix_gain      <= RST_MIX_GAIN;
            r_vbus_gain     <= RST_VBUS_GAIN;
            r_current_scale <= RST_CURRENT_SCALE;
            r_vbus_scale    <= RST_VBUS_SCALE;
            r_temp_cal      <= RST_TEMP_CAL;
            r_swap_bc       <= 1'b0;
            r_off_a         <= '0;
            r_off_b         <= '0;
            r_off_c         <= '0;
            r_vacc          <= RST_VBUS_ACC;
            r_state         <= ST_IDLE;
            r_op            <= OP_OFF_A;
            r_cnt           <= '0;
            r_div_busy      <= 1'b0;
            r_dcnt          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_OFFSET_GAIN:   r_offset_gain   <= i_cfg.data;
                    REG_MIX_GAIN:      r_mix_gain      <= i_cfg.data;
                    REG_VBUS_GAIN:     r_vbus_gain     <= i_cfg.data;
                    REG_CURRENT_SCALE: r_current_scale <= i_cfg.data;
                    REG_VBUS_SCALE:    r_vbus_scale    <= i_cfg.data;
                    REG_TEMP_CAL:      r_temp_cal      <= i_cfg.data[11:0];
                    REG_SWAP_BC:       r_swap_bc       <= i_cfg.data[0];
                    default: ;
                endcase
            end

            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (in_acc) begin
                r_div_busy <= 1'b1;
                r_dcnt     <= '0;
            end else if (r_div_busy) begin
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == DCW'(NW - 1)) begin
                    r_div_busy <= 1'b0;
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_op    <= OP_OFF_A;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) begin
                        r_state <= ST_STORE;
                    end
                end
                ST_STORE: begin
                    case (r_op)
                        OP_OFF_A: r_off_a <= r_off_a + w_sh16[W+15:0];
                        OP_OFF_B: r_off_b <= r_off_b + w_sh16[W+15:0];
                        OP_OFF_C: r_off_c <= r_off_c + w_sh16[W+15:0];
                        OP_VFILT: r_vacc  <= r_vacc + w_sh16[35:0];
                        default: ;
                    endcase
                    if (r_op == OP_VFILT) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_op    <= r_op + 1'b1;
                        r_state <= ST_LOAD;
                    end
                end
                ST_DONE: begin
                    if (!r_div_busy && out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s_off_a <= i_in.offset_sample_a;
            r_s_off_b <= i_in.offset_sample_b;
            r_s_off_c <= i_in.offset_sample_c;
            r_s_cur_a <= i_in.current_sample_a;
            r_s_cur_b <= i_in.current_sample_b;
            r_s_cur_c <= i_in.current_sample_c;
            r_s_vbus  <= i_in.vbus_sample;
            r_dnum    <= w_tnum;
            r_drem    <= '0;
            r_den     <= w_den;
        end else if (r_div_busy) begin
            r_dnum <= {r_dnum[NW-2:0], w_ge};
            r_drem <= w_ge ? w_rsub : w_rsh;
        end

        if (r_state == ST_LOAD) begin
            r_mcand  <= PW'(w_mcand);
            r_mplier <= w_mplier;
            r_prod   <= '0;
        end else if (r_state == ST_RUN) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end

        if (r_state == ST_STORE) begin
            case (r_op)
                OP_MIX:   r_kfl    <= w_nk[W+19:0];
                OP_CUR_A: r_cur_a  <= w_csat;
                OP_CUR_B: r_cur_b  <= w_csat;
                OP_CUR_C: r_cur_c  <= w_csat;
                OP_VTGT:  r_target <= w_tgt;
                default: ;
            endcase
        end

        if (r_state == ST_DONE && !r_div_busy && out_free) begin
            r_o_cur_a <= r_cur_a;
            r_o_cur_b <= r_swap_bc ? r_cur_c : r_cur_b;
            r_o_cur_c <= r_swap_bc ? r_cur_b : r_cur_c;
            r_o_temp  <= w_temp;
            r_o_vbus  <= w_vout;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.current_a   = r_o_cur_a;
    assign o_out.current_b   = r_o_cur_b;
    assign o_out.current_c   = r_o_cur_c;
    assign o_out.die_temp    = r_o_temp;
    assign o_out.bus_voltage = r_o_vbus;

    // ---------------- assertions ----------------
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_div_busy)
        else $error("divider still busy while idle");

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_LOAD && r_op == OP_OFF_A))
        else $error("transaction did not start the sequence");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_div_busy && out_free) |=>
        (r_out_valid && r_state == ST_IDLE))
        else $error("result not presented on completion");

    a_run_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_op <= OP_VFILT))
        else $error("operation counter out of range");

endmodule

`default_nettype wire
